FILE: rtl/tccc_pkg.sv
// ----------------------------------------------------------------------------
// tccc_pkg: text console cursor control package
// Shared types and codes for the cursor controller and its step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tccc_pkg;

    // Result actions
    localparam logic [1:0] ACT_DRAW   = 2'd0;
    localparam logic [1:0] ACT_SCROLL = 2'd1;
    localparam logic [1:0] ACT_BELL   = 2'd2;

    // Control characters
    localparam logic [7:0] CH_BEL   = 8'd7;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Register indexes
    localparam logic CFG_COLUMN_COUNT = 1'b0;
    localparam logic CFG_ROW_COUNT    = 1'b1;

    localparam logic [7:0] COLUMN_COUNT_RST = 8'd80;
    localparam logic [5:0] ROW_COUNT_RST    = 6'd24;
    localparam logic [6:0] COL_MAX          = 7'd127;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_SCROLL,
        ST_BELL
    } tccc_state_t;

    typedef enum logic [1:0] {
        DM_CHAR,
        DM_TAB,
        DM_ERASE
    } draw_mode_t;

    typedef struct packed {
        logic [6:0] col;
        logic [4:0] row;
        logic [6:0] wrap_col;
        logic [4:0] last_row;
        logic       force_nl;
    } step_req_t;

    typedef struct packed {
        logic [6:0] col_next;
        logic [4:0] row_next;
        logic       wrapped;
        logic       scroll;
    } step_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/tccc_step_unit.sv
// ----------------------------------------------------------------------------
// tccc_step_unit: cursor advance unit
// One cell step with wrap and newline; forced newline for LF.
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_step_unit
    import tccc_pkg::*;
(
    input  step_req_t req,
    output step_rsp_t rsp
);

    logic [7:0] col_inc;
    logic [5:0] row_inc;
    logic       wrapped;
    logic       scroll;

    always_comb begin
        col_inc = {1'b0, req.col} + 8'd1;
        row_inc = {1'b0, req.row} + 6'd1;
        wrapped = req.force_nl || (col_inc >= {1'b0, req.wrap_col});
        // row_inc can only reach 32 from row 31, which always scrolls
        scroll  = wrapped && (row_inc > {1'b0, req.last_row});

        rsp.wrapped  = wrapped;
        rsp.scroll   = scroll;
        rsp.col_next = wrapped ? 7'd0 : col_inc[6:0];
        if (!wrapped) begin
            rsp.row_next = req.row;
        end else if (scroll) begin
            rsp.row_next = req.last_row;
        end else begin
            rsp.row_next = row_inc[4:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/text_console_cursor_control.sv
// ----------------------------------------------------------------------------
// text_console_cursor_control: character-cell cursor controller
// Turns a byte stream into draw, scroll and bell beats for a text display.
// ----------------------------------------------------------------------------
// A taken byte sets the sequencer state; its result beats then go through the
//   output register. A byte gives N result beats (N = 0..8, a tab gives up to
//   seven space draws and a scroll); the sequencer issues one beat per cycle
//   through the single step unit, unless m_ready stalls, one byte at a time.
// Reset (aresetn low, synchronous): cursor at column 0 row 0, column_count 80,
//   row_count 24, no result pending.
`default_nettype none

module text_console_cursor_control
    import tccc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    // Input bytes
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,

    // Result beats
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_action,
    output logic [7:0]      m_glyph,
    output logic [6:0]      m_column,
    output logic [4:0]      m_row,
    output logic            m_last,

    // Register writes
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    tccc_state_t state_reg, state_next;
    draw_mode_t  mode_reg, mode_next;
    logic [7:0]  glyph_reg, glyph_next;
    logic [6:0]  col_reg, col_next;
    logic [4:0]  row_reg, row_next;
    logic [7:0]  column_count_reg;
    logic [5:0]  row_count_reg;

    // Output register
    logic        m_valid_reg;
    logic [1:0]  m_action_reg;
    logic [7:0]  m_glyph_reg;
    logic [6:0]  m_column_reg;
    logic [4:0]  m_row_reg;
    logic        m_last_reg;

    logic        out_load;
    logic [1:0]  out_action;
    logic [7:0]  out_glyph;
    logic [6:0]  out_column;
    logic [4:0]  out_row;
    logic        out_last;
    logic        slot_free;

    logic [6:0]  wrap_col;
    logic [4:0]  last_row;
    logic [6:0]  tab_col;

    step_req_t   step_req;
    step_rsp_t   step_rsp;

    // ------------------------------------------------------------------
    // Clamped geometry: wrap column in 1..127, last row in 0..31
    // ------------------------------------------------------------------
    always_comb begin
        priority if (column_count_reg < 8'd2) begin
            wrap_col = 7'd1;
        end else if (column_count_reg > 8'd128) begin
            wrap_col = COL_MAX;
        end else begin
            wrap_col = 7'(column_count_reg - 8'd1);
        end

        priority if (row_count_reg == 6'd0) begin
            last_row = 5'd0;
        end else if (row_count_reg > 6'd32) begin
            last_row = 5'd31;
        end else begin
            last_row = 5'(row_count_reg - 6'd1);
        end
    end

    // ------------------------------------------------------------------
    // Shared step unit. In idle it only serves LF, so the newline is forced.
    // ------------------------------------------------------------------
    always_comb begin
        step_req.col      = col_reg;
        step_req.row      = row_reg;
        step_req.wrap_col = wrap_col;
        step_req.last_row = last_row;
        step_req.force_nl = (state_reg == ST_IDLE);
    end

    tccc_step_unit u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    // Tab first steps one cell, saturating at column 127 (COL_MAX)
    assign tab_col   = (col_reg != COL_MAX) ? (col_reg + 7'd1) : col_reg;
    assign slot_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        glyph_next = glyph_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        out_load   = 1'b0;
        out_action = ACT_DRAW;
        out_glyph  = 8'd0;
        out_column = 7'd0;
        out_row    = 5'd0;
        out_last   = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_char_code)
                        CH_CR: begin
                            col_next = 7'd0;
                        end
                        CH_LF: begin
                            row_next = step_rsp.row_next;
                            if (step_rsp.scroll) begin
                                state_next = ST_SCROLL;
                            end
                        end
                        CH_BEL: begin
                            state_next = ST_BELL;
                        end
                        CH_TAB: begin
                            col_next = tab_col;
                            if (tab_col[2:0] != 3'd0) begin
                                state_next = ST_DRAW;
                                mode_next  = DM_TAB;
                                glyph_next = CH_SPACE;
                            end
                        end
                        CH_BS: begin
                            // nothing to erase at the left edge
                            if (col_reg != 7'd0) begin
                                col_next   = col_reg - 7'd1;
                                state_next = ST_DRAW;
                                mode_next  = DM_ERASE;
                                glyph_next = CH_SPACE;
                            end
                        end
                        default: begin
                            state_next = ST_DRAW;
                            mode_next  = DM_CHAR;
                            glyph_next = s_char_code;
                        end
                    endcase
                end
            end

            ST_DRAW: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_action = ACT_DRAW;
                    out_glyph  = glyph_reg;
                    out_column = col_reg;
                    out_row    = row_reg;
                    row_next   = step_rsp.row_next;
                    if (step_rsp.scroll) begin
                        // wrapped to column 0, scroll beat closes the byte
                        col_next   = 7'd0;
                        out_last   = 1'b0;
                        state_next = ST_SCROLL;
                    end else begin
                        unique case (mode_reg)
                            DM_TAB: begin
                                col_next = step_rsp.col_next;
                                if (step_rsp.col_next[2:0] != 3'd0) begin
                                    out_last = 1'b0;
                                end else begin
                                    state_next = ST_IDLE;
                                end
                            end
                            DM_ERASE: begin
                                // step back onto the erased cell
                                col_next   = step_rsp.wrapped ? 7'd0 : col_reg;
                                state_next = ST_IDLE;
                            end
                            default: begin
                                col_next   = step_rsp.col_next;
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            ST_SCROLL: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_action = ACT_SCROLL;
                    state_next = ST_IDLE;
                end
            end

            ST_BELL: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_action = ACT_BELL;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            col_reg          <= 7'd0;
            row_reg          <= 5'd0;
            column_count_reg <= COLUMN_COUNT_RST;
            row_count_reg    <= ROW_COUNT_RST;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    CFG_ROW_COUNT:    row_count_reg    <= cfg_data[5:0];
                    default:          column_count_reg <= column_count_reg;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        glyph_reg <= glyph_next;
        if (out_load) begin
            m_action_reg <= out_action;
            m_glyph_reg  <= out_glyph;
            m_column_reg <= out_column;
            m_row_reg    <= out_row;
            m_last_reg   <= out_last;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_action  = m_action_reg;
    assign m_glyph   = m_glyph_reg;
    assign m_column  = m_column_reg;
    assign m_row     = m_row_reg;
    assign m_last    = m_last_reg;

endmodule

`default_nettype wire
